>>> design/sol_pkg.sv
// ----------------------------------------------------------------------------
// sol_pkg
// Shared widths, operation codes and status codes of the self-organising
// array list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sol_pkg;

  // default capacity of the entry store
  localparam int unsigned DEPTH_DEF = 64;

  // field widths
  localparam int unsigned OP_W   = 4;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned LEN_W  = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_GET      = 4'd0;
  localparam logic [OP_W-1:0] OP_SET      = 4'd1;
  localparam logic [OP_W-1:0] OP_APPEND   = 4'd2;
  localparam logic [OP_W-1:0] OP_INSERT   = 4'd3;
  localparam logic [OP_W-1:0] OP_REM_AT   = 4'd4;
  localparam logic [OP_W-1:0] OP_REM_BACK = 4'd5;
  localparam logic [OP_W-1:0] OP_FIND     = 4'd6;
  localparam logic [OP_W-1:0] OP_FIND_TR  = 4'd7;
  localparam logic [OP_W-1:0] OP_ROT_L    = 4'd8;
  localparam logic [OP_W-1:0] OP_ROT_R    = 4'd9;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

>>> design/sol_if.sv
// ----------------------------------------------------------------------------
// sol_if
// Request and result channels of the self-organising array list unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface sol_in_if;
  logic                             valid;
  logic                             ready;
  logic [sol_pkg::OP_W-1:0]         operation;
  logic [sol_pkg::POS_W-1:0]        position;
  logic signed [sol_pkg::DATA_W-1:0] data_value;

  modport source (output valid, operation, position, data_value, input ready);
  modport sink   (input valid, operation, position, data_value, output ready);
endinterface

interface sol_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sol_pkg::DATA_W-1:0] result_value;
  logic [sol_pkg::IDX_W-1:0]        result_index;
  logic                             found;
  logic [sol_pkg::ST_W-1:0]         status;
  logic [sol_pkg::LEN_W-1:0]        length;

  modport source (output valid, result_value, result_index, found, status, length,
                  input ready);
  modport sink   (input valid, result_value, result_index, found, status, length,
                  output ready);
endinterface

`default_nettype wire

>>> design/sol_ram.sv
// ----------------------------------------------------------------------------
// sol_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/self_organizing_array_list_unit.sv
// ----------------------------------------------------------------------------
// self_organizing_array_list_unit
// Bounded array list of signed words held in a RAM, with get, set, append,
// insert, remove, search with optional transposition and rotations.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  in_ch    | in  | valid / ready     | operation, position, data_value
//  out_ch   | out | valid / ready     | result_value, result_index, found,
//           |     |                   | status, length
//
//  One request at a time; in_ch.ready is high only while the sequencer idles
//  out of reset. Get and remove back read one entry. Insert, remove at and
//  rotate left move one entry per cycle through the RAM port. Search may
//  end with a transposition of the hit. Rotate right is a copy through a
//  scratch RAM and back. No clearing pass after reset.
//  A result waiting on out_ch.ready holds the sequencer in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module self_organizing_array_list_unit #(
  parameter int unsigned DEPTH = sol_pkg::DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sol_in_if.sink      in_ch,
  sol_out_if.source   out_ch
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > sol_pkg::POS_W) ? CW : sol_pkg::POS_W;
  localparam int unsigned DW = sol_pkg::DATA_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_SHIFT = 10'b0000000100,
    S_TAIL  = 10'b0000001000,
    S_SCAN  = 10'b0000010000,
    S_SWAPW = 10'b0000100000,
    S_SWAPP = 10'b0001000000,
    S_ROT1  = 10'b0010000000,
    S_ROT2  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [AW-1:0] rp_r, rp_nxt, wa_r, wa_nxt, dp_r, dp_nxt, tail_a_r, tail_a_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          pv_r, pv_nxt, up_r, up_nxt, xpose_r, xpose_nxt;
  logic          tail_we_r, tail_we_nxt, cap_res_r, cap_res_nxt;
  logic          cap_tail_r, cap_tail_nxt;
  logic [DW-1:0] tail_d_r, tail_d_nxt;
  logic [DW-1:0] res_value_r, res_value_nxt;
  logic [sol_pkg::IDX_W-1:0] res_index_r, res_index_nxt;
  logic          res_found_r, res_found_nxt;
  logic [sol_pkg::ST_W-1:0] res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_value_r, out_value_nxt;
  logic [sol_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic          out_found_r, out_found_nxt;
  logic [sol_pkg::ST_W-1:0] out_status_r, out_status_nxt;
  logic [sol_pkg::LEN_W-1:0] out_len_r, out_len_nxt;

  logic          m_we, s_we;
  logic [AW-1:0] m_wa, m_ra, s_wa, s_ra;
  logic [DW-1:0] m_wd, m_rd, s_rd;

  logic [XW-1:0] pos_x, cnt_x;
  logic [AW-1:0] pos_a;
  logic          accept;

  // entry store and rotation scratch
  sol_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
  );

  sol_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_scratch (
    .clk, .we(s_we), .waddr(s_wa), .wdata(m_rd), .raddr(s_ra), .rdata(s_rd)
  );

  assign in_ch.ready         = (state_r == S_IDLE) && rst_n;
  assign accept              = in_ch.valid && in_ch.ready;
  assign pos_x               = XW'(in_ch.position);
  assign cnt_x               = XW'(count_r);
  assign pos_a               = AW'(in_ch.position);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.length       = out_len_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    val_nxt        = val_r;
    rp_nxt         = rp_r;
    wa_nxt         = wa_r;
    dp_nxt         = dp_r;
    left_nxt       = left_r;
    pv_nxt         = pv_r;
    up_nxt         = up_r;
    xpose_nxt      = xpose_r;
    tail_we_nxt    = tail_we_r;
    tail_a_nxt     = tail_a_r;
    tail_d_nxt     = tail_d_r;
    cap_res_nxt    = cap_res_r;
    cap_tail_nxt   = cap_tail_r;
    res_value_nxt  = res_value_r;
    res_index_nxt  = res_index_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    m_we = 1'b0;
    m_wa = wa_r;
    m_wd = m_rd;
    m_ra = rp_r;
    s_we = 1'b0;
    s_wa = wa_r;
    s_ra = rp_r;

    // result register drains independently
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt        = in_ch.data_value;
          res_value_nxt  = '0;
          res_index_nxt  = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = sol_pkg::ST_OK;
          pv_nxt         = 1'b0;
          cap_res_nxt    = 1'b0;
          cap_tail_nxt   = 1'b0;
          tail_we_nxt    = 1'b0;
          left_nxt       = '0;
          state_nxt      = S_DONE;
          unique case (in_ch.operation)
            sol_pkg::OP_GET: begin
              if (pos_x < cnt_x) begin
                m_ra        = pos_a;
                cap_res_nxt = 1'b1;
                state_nxt   = S_RD;
              end else begin
                res_status_nxt = sol_pkg::ST_RANGE;
              end
            end
            sol_pkg::OP_SET: begin
              if (pos_x < cnt_x) begin
                m_we = 1'b1;
                m_wa = pos_a;
                m_wd = in_ch.data_value;
              end else begin
                res_status_nxt = sol_pkg::ST_RANGE;
              end
            end
            sol_pkg::OP_APPEND: begin
              if (count_r >= CW'(DEPTH)) begin
                res_status_nxt = sol_pkg::ST_FULL;
              end else begin
                m_we      = 1'b1;
                m_wa      = AW'(count_r);
                m_wd      = in_ch.data_value;
                count_nxt = count_r + CW'(1);
              end
            end
            sol_pkg::OP_INSERT: begin
              if (pos_x >= cnt_x) begin
                res_status_nxt = sol_pkg::ST_RANGE;
              end else if (count_r >= CW'(DEPTH)) begin
                res_status_nxt = sol_pkg::ST_FULL;
              end else begin
                up_nxt      = 1'b1;
                rp_nxt      = AW'(count_r - CW'(1));
                left_nxt    = CW'(cnt_x - pos_x);
                tail_we_nxt = 1'b1;
                tail_a_nxt  = pos_a;
                tail_d_nxt  = in_ch.data_value;
                count_nxt   = count_r + CW'(1);
                state_nxt   = S_SHIFT;
              end
            end
            sol_pkg::OP_REM_AT: begin
              if (count_r == '0) begin
                res_status_nxt = sol_pkg::ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res_status_nxt = sol_pkg::ST_RANGE;
              end else begin
                m_ra        = pos_a;
                cap_res_nxt = 1'b1;
                up_nxt      = 1'b0;
                rp_nxt      = pos_a + AW'(1);
                left_nxt    = CW'(cnt_x - pos_x - XW'(1));
                count_nxt   = count_r - CW'(1);
                state_nxt   = S_RD;
              end
            end
            sol_pkg::OP_REM_BACK: begin
              if (count_r == '0) begin
                res_status_nxt = sol_pkg::ST_EMPTY;
              end else begin
                m_ra        = AW'(count_r - CW'(1));
                cap_res_nxt = 1'b1;
                count_nxt   = count_r - CW'(1);
                state_nxt   = S_RD;
              end
            end
            sol_pkg::OP_FIND, sol_pkg::OP_FIND_TR: begin
              rp_nxt         = '0;
              left_nxt       = count_r;
              xpose_nxt      = (in_ch.operation == sol_pkg::OP_FIND_TR);
              res_status_nxt = sol_pkg::ST_NOTFOUND;
              state_nxt      = S_SCAN;
            end
            sol_pkg::OP_ROT_L: begin
              if (count_r == '0) begin
                res_status_nxt = sol_pkg::ST_EMPTY;
              end else begin
                m_ra         = '0;
                cap_tail_nxt = 1'b1;
                up_nxt       = 1'b0;
                rp_nxt       = AW'(1);
                left_nxt     = count_r - CW'(1);
                tail_we_nxt  = 1'b1;
                tail_a_nxt   = AW'(count_r - CW'(1));
                state_nxt    = S_RD;
              end
            end
            sol_pkg::OP_ROT_R: begin
              if (pos_x > cnt_x) begin
                res_status_nxt = sol_pkg::ST_RANGE;
              end else if (pos_x != '0 && pos_x < cnt_x) begin
                rp_nxt    = '0;
                left_nxt  = count_r;
                dp_nxt    = pos_a;
                state_nxt = S_ROT1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // first read lands: value for the result or the saved front entry
      S_RD: begin
        if (cap_res_r) begin
          res_value_nxt = m_rd;
        end
        if (cap_tail_r) begin
          tail_d_nxt = m_rd;
        end
        state_nxt = S_SHIFT;
      end

      // move one entry per cycle, up or down by one place
      S_SHIFT: begin
        if (pv_r) begin
          m_we = 1'b1;
          m_wa = wa_r;
          m_wd = m_rd;
        end
        if (left_r != '0) begin
          m_ra     = rp_r;
          rp_nxt   = up_r ? rp_r - AW'(1) : rp_r + AW'(1);
          wa_nxt   = up_r ? rp_r + AW'(1) : rp_r - AW'(1);
          left_nxt = left_r - CW'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = S_TAIL;
          end
        end
      end

      // closing write of insert or rotate left
      S_TAIL: begin
        if (tail_we_r) begin
          m_we = 1'b1;
          m_wa = tail_a_r;
          m_wd = tail_d_r;
        end
        state_nxt = S_DONE;
      end

      // linear search, compare in the cycle after the read
      S_SCAN: begin
        if (pv_r && (m_rd == val_r)) begin
          res_found_nxt  = 1'b1;
          res_status_nxt = sol_pkg::ST_OK;
          res_index_nxt  = sol_pkg::IDX_W'(wa_r);
          pv_nxt         = 1'b0;
          if (xpose_r && wa_r != '0) begin
            m_ra      = wa_r - AW'(1);
            state_nxt = S_SWAPW;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (left_r != '0) begin
          m_ra     = rp_r;
          wa_nxt   = rp_r;
          rp_nxt   = rp_r + AW'(1);
          left_nxt = left_r - CW'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      // predecessor moves up into the hit slot
      S_SWAPW: begin
        m_we      = 1'b1;
        m_wa      = wa_r;
        m_wd      = m_rd;
        state_nxt = S_SWAPP;
      end

      // found value goes one place to the front
      S_SWAPP: begin
        m_we          = 1'b1;
        m_wa          = wa_r - AW'(1);
        m_wd          = val_r;
        res_index_nxt = sol_pkg::IDX_W'(wa_r - AW'(1));
        state_nxt     = S_DONE;
      end

      // copy to scratch at the rotated place
      S_ROT1: begin
        if (pv_r) begin
          s_we = 1'b1;
          s_wa = wa_r;
        end
        if (left_r != '0) begin
          m_ra     = rp_r;
          rp_nxt   = rp_r + AW'(1);
          left_nxt = left_r - CW'(1);
          wa_nxt   = dp_r;
          dp_nxt   = (CW'(dp_r) + CW'(1) == count_r) ? '0 : dp_r + AW'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            rp_nxt    = '0;
            left_nxt  = count_r;
            state_nxt = S_ROT2;
          end
        end
      end

      // copy scratch back in order
      S_ROT2: begin
        if (pv_r) begin
          m_we = 1'b1;
          m_wa = wa_r;
          m_wd = s_rd;
        end
        if (left_r != '0) begin
          s_ra     = rp_r;
          wa_nxt   = rp_r;
          rp_nxt   = rp_r + AW'(1);
          left_nxt = left_r - CW'(1);
          pv_nxt   = 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_index_nxt  = res_index_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_len_nxt    = sol_pkg::LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    rp_r         <= rp_nxt;
    wa_r         <= wa_nxt;
    dp_r         <= dp_nxt;
    left_r       <= left_nxt;
    up_r         <= up_nxt;
    xpose_r      <= xpose_nxt;
    tail_we_r    <= tail_we_nxt;
    tail_a_r     <= tail_a_nxt;
    tail_d_r     <= tail_d_nxt;
    cap_res_r    <= cap_res_nxt;
    cap_tail_r   <= cap_tail_nxt;
    res_value_r  <= res_value_nxt;
    res_index_r  <= res_index_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

endmodule

`default_nettype wire
